/* rtl/fbd_pkg.sv */
`timescale 1ns / 1ps

package fbd_pkg;

  // Field widths of the button sample and the result.
  localparam int LEVEL_W = 4;
  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;
  localparam int CH_W    = 2;

  // Default button count and register reset value.
  localparam int          NUM_BUTTONS_DEF    = 4;
  localparam logic [15:0] DEBOUNCE_RESET     = 16'd50;

  // Number of held buttons that toggles the menu on a selection press.
  localparam int          DOUBLE_PRESS_COUNT = 2;

  // One result item.
  typedef struct packed {
    logic               note_on_valid;
    logic [CH_W-1:0]    note_on_channel;
    logic [LEVEL_W-1:0] note_off_mask;
    logic [LEVEL_W-1:0] pressed_mask;
    logic [CH_W-1:0]    selected_channel;
    logic               channel_changed;
    logic               menu_active;
    logic               redraw;
  } fbd_result_t;

endpackage

/* rtl/fbd_in_if.sv */
`timescale 1ns / 1ps

// Button sample channel.
interface fbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [fbd_pkg::LEVEL_W-1:0]  button_levels;
  logic [fbd_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, output button_levels, output time_ms, input ready);
  modport sink   (input valid, input button_levels, input time_ms, output ready);
endinterface

/* rtl/fbd_out_if.sv */
`timescale 1ns / 1ps

// Result channel.
interface fbd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         note_on_valid;
  logic [fbd_pkg::CH_W-1:0]     note_on_channel;
  logic [fbd_pkg::LEVEL_W-1:0]  note_off_mask;
  logic [fbd_pkg::LEVEL_W-1:0]  pressed_mask;
  logic [fbd_pkg::CH_W-1:0]     selected_channel;
  logic                         channel_changed;
  logic                         menu_active;
  logic                         redraw;

  modport source (output valid, output note_on_valid, output note_on_channel,
                  output note_off_mask, output pressed_mask, output selected_channel,
                  output channel_changed, output menu_active, output redraw,
                  input ready);
  modport sink   (input valid, input note_on_valid, input note_on_channel,
                  input note_off_mask, input pressed_mask, input selected_channel,
                  input channel_changed, input menu_active, input redraw,
                  output ready);
endinterface

/* rtl/fbd_step.sv */
`timescale 1ns / 1ps

// Next-state and result logic for one sample: the buttons are handled in
// order, each one seeing the selection and pressed state left by the ones
// before it.
module fbd_step #(
  parameter int NUM_LANES = fbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic [fbd_pkg::LEVEL_W-1:0]                 levels,
  input  logic [fbd_pkg::TIME_W-1:0]                  now,
  input  logic [fbd_pkg::DEB_W-1:0]                   debounce_ms,
  input  logic [NUM_LANES-1:0]                        raw_last,
  input  logic [NUM_LANES-1:0][fbd_pkg::TIME_W-1:0]   change_time,
  input  logic [NUM_LANES-1:0]                        pressed,
  input  logic [NUM_LANES-1:0]                        armed,
  input  logic [fbd_pkg::CH_W-1:0]                    channel,
  input  logic                                        menu,
  output logic [NUM_LANES-1:0]                        raw_last_nxt,
  output logic [NUM_LANES-1:0][fbd_pkg::TIME_W-1:0]   change_time_nxt,
  output logic [NUM_LANES-1:0]                        pressed_nxt,
  output logic [NUM_LANES-1:0]                        armed_nxt,
  output logic [fbd_pkg::CH_W-1:0]                    channel_nxt,
  output logic                                        menu_nxt,
  output fbd_pkg::fbd_result_t                        result
);

  localparam int CH_W    = fbd_pkg::CH_W;
  localparam int TIME_W  = fbd_pkg::TIME_W;
  localparam int LEVEL_W = fbd_pkg::LEVEL_W;

  logic [NUM_LANES-1:0] steady;

  // A level is accepted only when it matches the last sample and has been
  // stable for strictly longer than the debounce time. All lanes in parallel.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      raw_last_nxt[i]    = levels[i];
      change_time_nxt[i] = (levels[i] != raw_last[i]) ? now : change_time[i];
      steady[i]          = (levels[i] == raw_last[i]) &&
                           ((now - change_time[i]) > TIME_W'(debounce_ms));
    end
  end

  // Ordered press and release handling across the buttons.
  always_comb begin
    logic [NUM_LANES-1:0] pr;
    logic [NUM_LANES-1:0] arm;
    logic [CH_W-1:0]      ch;
    logic                 mnu;
    logic                 on_valid;
    logic [CH_W-1:0]      on_ch;
    logic [LEVEL_W-1:0]   off_mask;
    logic [LEVEL_W-1:0]   pmask;
    logic                 changed;
    logic                 redraw;
    pr       = pressed;
    arm      = armed;
    ch       = channel;
    mnu      = menu;
    on_valid = 1'b0;
    on_ch    = '0;
    off_mask = '0;
    pmask    = '0;
    changed  = 1'b0;
    redraw   = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (steady[i] && !levels[i] && !pr[i]) begin
        pr[i] = 1'b1;
        if (ch == CH_W'(i)) begin
          on_valid = 1'b1;
          on_ch    = CH_W'(i);
          arm[i]   = 1'b1;
        end else begin
          if ($countones(pr) == fbd_pkg::DOUBLE_PRESS_COUNT) begin
            mnu = ~mnu;
          end
          ch      = CH_W'(i);
          changed = 1'b1;
        end
        redraw = 1'b1;
      end else if (steady[i] && levels[i] && pr[i]) begin
        pr[i] = 1'b0;
        if (arm[i]) begin
          off_mask[i] = 1'b1;
          arm[i]      = 1'b0;
        end
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      pmask[i] = pr[i];
    end

    pressed_nxt              = pr;
    armed_nxt                = arm;
    channel_nxt              = ch;
    menu_nxt                 = mnu;
    result.note_on_valid     = on_valid;
    result.note_on_channel   = on_ch;
    result.note_off_mask     = off_mask;
    result.pressed_mask      = pmask;
    result.selected_channel  = ch;
    result.channel_changed   = changed;
    result.menu_active       = mnu;
    result.redraw            = redraw;
  end

endmodule

/* rtl/four_button_debounce_channel_select_unit.sv */
`timescale 1ns / 1ps

// Debounces up to four active-low buttons against a wrapping millisecond
// time and turns accepted presses into note-on, note-off, channel select
// and menu toggle events. One sample item is accepted every clock cycle
// while the input side is not stalled. The sample is held in an input
// register, and the four-button decision chain plus the state update run
// into the result register. Button state is written on the same commit as
// the result, so back-to-back samples need no bubbles. A stalled result
// keeps the input register full; only then does the input side stall. The
// debounce register (reset 50 ms) is written through cfg_wr_en/cfg_wr_data.
module four_button_debounce_channel_select_unit #(
  parameter int NUM_BUTTONS = fbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fbd_in_if.sink                     in_chan,
  fbd_out_if.source                  out_chan,
  input  logic                       cfg_wr_en,
  input  logic [fbd_pkg::DEB_W-1:0]  cfg_wr_data
);

  // Only the buttons that have a pin in the sample can ever be pressed.
  localparam int NUM_LANES = (NUM_BUTTONS < fbd_pkg::LEVEL_W) ?
                             NUM_BUTTONS : fbd_pkg::LEVEL_W;
  localparam int TIME_W    = fbd_pkg::TIME_W;

  // Handshake and pipeline control.
  logic advance;
  logic commit;

  logic                               s1_valid_r;
  logic [fbd_pkg::LEVEL_W-1:0]        s1_levels_r;
  logic [TIME_W-1:0]                  s1_time_r;
  logic                               out_valid_r;
  fbd_pkg::fbd_result_t               res_r;
  fbd_pkg::fbd_result_t               res_nxt;

  // Debounce register and per-button state.
  logic [fbd_pkg::DEB_W-1:0]          debounce_r;
  logic [NUM_LANES-1:0]               raw_last_r;
  logic [NUM_LANES-1:0]               raw_last_nxt;
  logic [NUM_LANES-1:0][TIME_W-1:0]   change_time_r;
  logic [NUM_LANES-1:0][TIME_W-1:0]   change_time_nxt;
  logic [NUM_LANES-1:0]               pressed_r;
  logic [NUM_LANES-1:0]               pressed_nxt;
  logic [NUM_LANES-1:0]               armed_r;
  logic [NUM_LANES-1:0]               armed_nxt;
  logic [fbd_pkg::CH_W-1:0]           channel_r;
  logic [fbd_pkg::CH_W-1:0]           channel_nxt;
  logic                               menu_r;
  logic                               menu_nxt;

  assign advance       = !out_valid_r || out_chan.ready;
  assign commit        = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;

  // Decision logic for the sample in the input register.
  fbd_step #(
    .NUM_LANES (NUM_LANES)
  ) u_step (
    .levels          (s1_levels_r),
    .now             (s1_time_r),
    .debounce_ms     (debounce_r),
    .raw_last        (raw_last_r),
    .change_time     (change_time_r),
    .pressed         (pressed_r),
    .armed           (armed_r),
    .channel         (channel_r),
    .menu            (menu_r),
    .raw_last_nxt    (raw_last_nxt),
    .change_time_nxt (change_time_nxt),
    .pressed_nxt     (pressed_nxt),
    .armed_nxt       (armed_nxt),
    .channel_nxt     (channel_nxt),
    .menu_nxt        (menu_nxt),
    .result          (res_nxt)
  );

  // Control, configuration and button state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      debounce_r    <= fbd_pkg::DEBOUNCE_RESET;
      raw_last_r    <= '1;
      change_time_r <= '0;
      pressed_r     <= '0;
      armed_r       <= '0;
      channel_r     <= '0;
      menu_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        debounce_r <= cfg_wr_data;
      end
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (commit) begin
        raw_last_r    <= raw_last_nxt;
        change_time_r <= change_time_nxt;
        pressed_r     <= pressed_nxt;
        armed_r       <= armed_nxt;
        channel_r     <= channel_nxt;
        menu_r        <= menu_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_levels_r <= in_chan.button_levels;
      s1_time_r   <= in_chan.time_ms;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  // Result channel.
  assign out_chan.valid            = out_valid_r;
  assign out_chan.note_on_valid    = res_r.note_on_valid;
  assign out_chan.note_on_channel  = res_r.note_on_channel;
  assign out_chan.note_off_mask    = res_r.note_off_mask;
  assign out_chan.pressed_mask     = res_r.pressed_mask;
  assign out_chan.selected_channel = res_r.selected_channel;
  assign out_chan.channel_changed  = res_r.channel_changed;
  assign out_chan.menu_active      = res_r.menu_active;
  assign out_chan.redraw           = res_r.redraw;

  // Every accepted press is either a note-on or a selection change.
  a_redraw_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.redraw == (res_r.note_on_valid || res_r.channel_changed)))
    else $error("redraw does not match note-on or selection change");

  // Without a note-on the reported channel is zero.
  a_note_on_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.note_on_valid) |-> (res_r.note_on_channel == '0))
    else $error("note-on channel set without a note-on");

  // Button state only moves when a sample is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> ($stable(pressed_r) && $stable(armed_r) && $stable(channel_r) &&
                 $stable(menu_r)))
    else $error("button state changed without a processed item");

  // The input side only stalls when both stages hold data and output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");

endmodule

/* bench/four_button_debounce_channel_select_unit_tb.sv */
`timescale 1ns / 1ps

module four_button_debounce_channel_select_unit_tb;

  localparam int LEVEL_W = fbd_pkg::LEVEL_W;
  localparam int TIME_W  = fbd_pkg::TIME_W;
  localparam int DEB_W   = fbd_pkg::DEB_W;
  localparam int CH_W    = fbd_pkg::CH_W;
  localparam int DOUBLE_PRESS_COUNT = fbd_pkg::DOUBLE_PRESS_COUNT;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = fbd_pkg::DEBOUNCE_RESET;

  typedef fbd_pkg::fbd_result_t fbd_result_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 265;

  // One directed sample, with a hand-written result where it is obvious.
  typedef struct {
    logic [LEVEL_W-1:0] levels;
    logic [TIME_W-1:0]  now;
    bit                 known;
    fbd_result_t        res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [DEB_W-1:0] cfg_wr_data;

  fbd_in_if  in_chan ();
  fbd_out_if out_chan ();

  four_button_debounce_channel_select_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the button state.
  logic [LEVEL_W-1:0] lvl_seen;
  logic [TIME_W-1:0]  stamp_ms [LEVEL_W];
  logic [LEVEL_W-1:0] held_q;
  logic [LEVEL_W-1:0] armed_q;
  logic [CH_W-1:0]    chan_q;
  logic               menu_q;
  logic [DEB_W-1:0]   deb_q;

  fbd_result_t pending_results [$];
  stim_row_t   dir_rows [$];
  int          mismatch_cnt = 0;
  int          cyc_cnt = 0;
  bit          src_gaps_on = 1'b1;
  bit          snk_stalls_on = 1'b1;
  int          stall_left = 0;

  function automatic fbd_result_t mk_res(bit on, bit [1:0] ch, bit [3:0] off, bit [3:0] pm,
                                         bit [1:0] sel, bit chg, bit menu, bit rd);
    fbd_result_t r;
    r.note_on_valid    = on;
    r.note_on_channel  = ch;
    r.note_off_mask    = off;
    r.pressed_mask     = pm;
    r.selected_channel = sel;
    r.channel_changed  = chg;
    r.menu_active      = menu;
    r.redraw           = rd;
    return r;
  endfunction

  // Runs one sample through the button chain, in order from button one up,
  // and updates the shadow state.
  function automatic fbd_result_t debounce_tick(logic [LEVEL_W-1:0] lv, logic [TIME_W-1:0] now);
    fbd_result_t r;
    logic [TIME_W-1:0] elapsed;
    bit taken;
    r = '0;
    for (int i = 0; i < LEVEL_W; i++) begin
      taken = 1'b0;
      if (lv[i] != lvl_seen[i]) stamp_ms[i] = now;
      elapsed = now - stamp_ms[i];
      if (elapsed > {16'd0, deb_q}) begin
        if (!lv[i] && !held_q[i]) begin
          held_q[i] = 1'b1;
          if (chan_q == CH_W'(i)) begin
            r.note_on_valid   = 1'b1;
            r.note_on_channel = CH_W'(i);
            armed_q[i]        = 1'b1;
          end else begin
            // Selecting with exactly two buttons held flips the menu.
            if ($countones(held_q) == DOUBLE_PRESS_COUNT) menu_q = ~menu_q;
            chan_q            = CH_W'(i);
            r.channel_changed = 1'b1;
          end
          r.redraw = 1'b1;
          taken    = 1'b1;
        end else if (lv[i] && held_q[i]) begin
          held_q[i] = 1'b0;
          if (armed_q[i]) begin
            r.note_off_mask[i] = 1'b1;
            armed_q[i]         = 1'b0;
          end
          taken = 1'b1;
        end
      end
      if (!taken) lvl_seen[i] = lv[i];
    end
    r.pressed_mask     = held_q;
    r.selected_channel = chan_q;
    r.menu_active      = menu_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [3:0] got, input logic [3:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int pick_gap();
    int r;
    if (!src_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offers one sample item and records what it should produce.
  task automatic push_sample(input logic [LEVEL_W-1:0] lv, input logic [TIME_W-1:0] now,
                             input bit known, input fbd_result_t want);
    fbd_result_t pred;
    int gap;
    in_chan.valid         <= 1'b1;
    in_chan.button_levels <= lv;
    in_chan.time_ms       <= now;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pred = debounce_tick(lv, now);
    pending_results.push_back(known ? want : pred);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every result is back and the pipe is empty.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [DEB_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    deb_q = value;
  endtask

  // Result side: compare accepted items, then choose the next ready level.
  always @(posedge clk) begin
    fbd_result_t got;
    fbd_result_t want;
    logic rdy_next;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.note_on_valid    = out_chan.note_on_valid;
      got.note_on_channel  = out_chan.note_on_channel;
      got.note_off_mask    = out_chan.note_off_mask;
      got.pressed_mask     = out_chan.pressed_mask;
      got.selected_channel = out_chan.selected_channel;
      got.channel_changed  = out_chan.channel_changed;
      got.menu_active      = out_chan.menu_active;
      got.redraw           = out_chan.redraw;
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pending_results.pop_front();
        cmp_field("note_on_valid", got.note_on_valid, want.note_on_valid);
        cmp_field("note_on_channel", got.note_on_channel, want.note_on_channel);
        cmp_field("note_off_mask", got.note_off_mask, want.note_off_mask);
        cmp_field("pressed_mask", got.pressed_mask, want.pressed_mask);
        cmp_field("selected_channel", got.selected_channel, want.selected_channel);
        cmp_field("channel_changed", got.channel_changed, want.channel_changed);
        cmp_field("menu_active", got.menu_active, want.menu_active);
        cmp_field("redraw", got.redraw, want.redraw);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      rdy_next = 1'b0;
    end else if (snk_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      rdy_next   = 1'b0;
    end else begin
      rdy_next = 1'b1;
    end
    out_chan.ready <= rdy_next;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [DEB_W-1:0]   deb_plan [6];
    logic [LEVEL_W-1:0] lv_cur;
    logic [TIME_W-1:0]  now_ms;
    int unsigned deb_i;
    int unsigned dt;
    int r;

    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    in_chan.valid          = 1'b0;
    in_chan.button_levels  = '1;
    in_chan.time_ms        = '0;
    out_chan.ready         = 1'b0;

    lvl_seen = '1;
    held_q   = '0;
    armed_q  = '0;
    chan_q   = '0;
    menu_q   = 1'b0;
    deb_q    = DEBOUNCE_RESET;
    for (int i = 0; i < LEVEL_W; i++) stamp_ms[i] = '0;

    // Directed walk at the reset debounce of 50 ms: note-on and note-off on
    // channel one, selection, menu toggle with two held, all four at once,
    // selection that ends where it started, note-on on channel four, the
    // steady time exactly equal to the debounce, and a time wrap.
    dir_rows = '{
      '{4'hF, 32'd0,    1'b1, mk_res(0, 0, 4'h0, 4'h0, 0, 0, 0, 0)},
      '{4'hE, 32'd100,  1'b1, mk_res(0, 0, 4'h0, 4'h0, 0, 0, 0, 0)},
      '{4'hE, 32'd151,  1'b1, mk_res(1, 0, 4'h0, 4'h1, 0, 0, 0, 1)},
      '{4'hF, 32'd160,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd211,  1'b1, mk_res(0, 0, 4'h1, 4'h0, 0, 0, 0, 0)},
      '{4'hD, 32'd300,  1'b0, fbd_result_t'('0)},
      '{4'hD, 32'd351,  1'b0, fbd_result_t'('0)},
      '{4'h9, 32'd400,  1'b0, fbd_result_t'('0)},
      '{4'h9, 32'd451,  1'b0, fbd_result_t'('0)},
      '{4'h0, 32'd500,  1'b0, fbd_result_t'('0)},
      '{4'h0, 32'd551,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd600,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd651,  1'b0, fbd_result_t'('0)},
      '{4'h6, 32'd700,  1'b0, fbd_result_t'('0)},
      '{4'h6, 32'd751,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd800,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd851,  1'b0, fbd_result_t'('0)},
      '{4'h7, 32'd900,  1'b0, fbd_result_t'('0)},
      '{4'h7, 32'd951,  1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd1000, 1'b0, fbd_result_t'('0)},
      '{4'hF, 32'd1051, 1'b0, fbd_result_t'('0)},
      '{4'hE, 32'd1100, 1'b0, fbd_result_t'('0)},
      '{4'hE, 32'd1150, 1'b1, mk_res(0, 0, 4'h0, 4'h0, 3, 0, 0, 0)},
      '{4'hE, 32'd1151, 1'b0, fbd_result_t'('0)},
      '{4'hF, 32'hFFFF_FFFF, 1'b0, fbd_result_t'('0)},
      '{4'hF, 32'h0000_0040, 1'b0, fbd_result_t'('0)}
    };

    deb_plan[0] = 16'd0;
    deb_plan[1] = 16'hFFFF;
    deb_plan[2] = 16'd1;
    deb_plan[3] = DEB_W'($urandom_range(2, 400));
    deb_plan[4] = 16'd7;
    deb_plan[5] = DEBOUNCE_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) push_sample(dir_rows[k].levels, dir_rows[k].now,
                                      dir_rows[k].known, dir_rows[k].res);

    // Random phases, one debounce setting each. Mostly steady levels with
    // single-button presses and releases; some bounce and time jumps.
    lv_cur = '1;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_debounce(deb_plan[p]);
      src_gaps_on   = (p != 2);
      snk_stalls_on = (p != 4);
      deb_i  = deb_q;
      now_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 22) lv_cur[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
        else if (r < 26) lv_cur = LEVEL_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 60) dt = $urandom_range(0, deb_i / 4 + 2);
        else if (r < 97) dt = $urandom_range(deb_i / 2, deb_i * 2 + 2);
        else dt = $urandom;
        now_ms += dt;
        push_sample(lv_cur, now_ms, 1'b0, fbd_result_t'('0));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
